### hdl/pud_pkg.sv
// Package: constants, codes and hex digit helpers for the percent unescape decoder.
`default_nettype none
package pud_pkg;

	// escape introducer
	localparam logic [7:0] PCT_CHAR = 8'h25;

	// result queue geometry (depth must be a power of two, at least 4)
	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	// most results one request can cause
	localparam int MAX_RES = 3;

	// pending state codes
	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_PCT   = 2'd1,
		PEND_DIGIT = 2'd2
	} pend_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} res_t;

	function automatic logic hex_ok(input logic [7:0] b);
		hex_ok = (b >= 8'h30 && b <= 8'h39) ||
			(b >= 8'h41 && b <= 8'h46) ||
			(b >= 8'h61 && b <= 8'h66);
	endfunction

	// value of a hex digit; meaningless for a non-digit
	function automatic logic [3:0] hex_val(input logic [7:0] b);
		logic [7:0] v;
		if (b <= 8'h39) begin
			v = b - 8'h30;
		end else if (b <= 8'h46) begin
			v = b - 8'h37;
		end else begin
			v = b - 8'h57;
		end
		hex_val = v[3:0];
	endfunction

endpackage
`default_nettype wire

### hdl/percent_unescape_decoder_top.sv
// Top level: streaming %XY unescape decoder with result queue.
// A result can leave the queue in the cycle after its request is accepted, at the earliest.
// Throughput: one request per cycle unless in_stall; a request causes 0 to 3 results, which
// drain at one per cycle unless out_stall, through an 8-entry result queue. The request side
// stalls when fewer than three queue entries are free; the drain port sets the sustained rate.
// Reset (arst_n low, asynchronous): nothing pending, held digit zero, queue empty.
`default_nettype none
module percent_unescape_decoder_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// request channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       line_end,
	// result channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	localparam int PW = pud_pkg::QPTR_W;
	localparam int CW = pud_pkg::QCNT_W;

	// decoder state
	pud_pkg::pend_t pend_q;
	logic [7:0]     held_q;

	// result queue: small flop array, written at up to three slots, read at the head
	pud_pkg::res_t  queue_q [pud_pkg::QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	// decode outputs for the current request
	logic [7:0]     slot_data [pud_pkg::MAX_RES];
	logic [1:0]     n_res;
	pud_pkg::pend_t pend_nx;
	logic [7:0]     held_nx;
	logic [1:0]     last_idx;

	logic in_acc;
	logic out_acc;

	// Stall from the registered count only: room for a full burst of three results.
	assign in_stall = (count_q > CW'(pud_pkg::QDEPTH - pud_pkg::MAX_RES));
	assign in_acc   = in_valid && !in_stall;

	assign out_valid = (count_q != '0);
	assign out_acc   = out_valid && !out_stall;
	assign out_byte  = queue_q[rd_ptr_q].data;
	assign out_last  = queue_q[rd_ptr_q].last;

	// Single-pass decode. Results are packed into slots in emission order.
	always_comb begin
		logic       b_hex;
		logic [1:0] cnt;
		b_hex = pud_pkg::hex_ok(data_byte);
		cnt   = pend_q;
		for (int i = 0; i < pud_pkg::MAX_RES; i++) begin
			slot_data[i] = data_byte;
		end
		n_res   = 2'd0;
		held_nx = held_q;
		pend_nx = pud_pkg::PEND_NONE;

		if (cnt == pud_pkg::PEND_DIGIT && b_hex) begin
			// escape complete
			slot_data[0] = {pud_pkg::hex_val(held_q), pud_pkg::hex_val(data_byte)};
			n_res        = 2'd1;
		end else if (cnt == pud_pkg::PEND_PCT && b_hex) begin
			// first digit after '%'
			held_nx = data_byte;
			pend_nx = pud_pkg::PEND_DIGIT;
		end else begin
			// broken or no escape: flush pending literally, then look at this byte
			if (cnt == pud_pkg::PEND_PCT || cnt == pud_pkg::PEND_DIGIT) begin
				slot_data[n_res] = pud_pkg::PCT_CHAR;
				n_res            = n_res + 2'd1;
			end
			if (cnt == pud_pkg::PEND_DIGIT) begin
				slot_data[n_res] = held_q;
				n_res            = n_res + 2'd1;
			end
			if (data_byte == pud_pkg::PCT_CHAR) begin
				pend_nx = pud_pkg::PEND_PCT;
			end else begin
				slot_data[n_res] = data_byte;
				n_res            = n_res + 2'd1;
			end
		end

		// line end: flush whatever is still held
		if (line_end) begin
			if (pend_nx != pud_pkg::PEND_NONE) begin
				slot_data[n_res] = pud_pkg::PCT_CHAR;
				n_res            = n_res + 2'd1;
			end
			if (pend_nx == pud_pkg::PEND_DIGIT) begin
				slot_data[n_res] = held_nx;
				n_res            = n_res + 2'd1;
			end
			pend_nx = pud_pkg::PEND_NONE;
			held_nx = 8'h00;
		end

		last_idx = n_res - 2'd1;
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= pud_pkg::PEND_NONE;
			held_q <= 8'h00;
		end else if (in_acc) begin
			pend_q <= pend_nx;
			held_q <= held_nx;
		end
	end

	// queue payload; no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < pud_pkg::MAX_RES; i++) begin
				if (2'(i) < n_res) begin
					queue_q[wr_ptr_q + PW'(i)].data <= slot_data[i];
					queue_q[wr_ptr_q + PW'(i)].last <= line_end && (2'(i) == last_idx);
				end
			end
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_acc) begin
				wr_ptr_q <= wr_ptr_q + PW'(n_res);
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + (in_acc ? CW'(n_res) : CW'(0)) - (out_acc ? CW'(1) : CW'(0));
		end
	end

endmodule
`default_nettype wire

### test/percent_unescape_decoder_top_tb.sv
// Testbench: percent unescape decoder top level, directed and random lines against a built-in predictor.
`default_nettype none
module percent_unescape_decoder_top_tb;

	// The run must end well before this, even with the slowest legal pacing:
	// ~460 requests, up to 3 bytes each, the longest idle and stall runs on both sides.
	localparam int RUN_LIMIT = 6_000_000;
	localparam int RANDOM_REQUESTS = 430;
	localparam int END_SETTLE = 20;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       line_end;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;

	// quiet = no idling on either side, to get back-to-back traffic
	bit quiet = 1'b0;
	int requests_sent = 0;
	int lines_sent = 0;
	int stall_left = 0;

	percent_unescape_decoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.line_end(line_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.out_last(out_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hex digit value 0..15, or 16 for anything that is not a hex digit (NUL included).
	function automatic logic [4:0] hex_digit_value(input logic [7:0] b);
		if (b >= "0" && b <= "9") return 5'(b - "0");
		if (b >= "A" && b <= "F") return 5'(b - "A" + 8'd10);
		if (b >= "a" && b <= "f") return 5'(b - "a" + 8'd10);
		return 5'd16;
	endfunction

	// Tracks the decoder's pending state and the queue of bytes it must emit.
	class unescape_scoreboard;
		pud_pkg::pend_t pend;
		logic [7:0]     held;
		pud_pkg::res_t  decoded_q[$];
		int             errors;

		function new();
			pend = pud_pkg::PEND_NONE;
			held = 8'h00;
			errors = 0;
		endfunction

		function int outstanding();
			return decoded_q.size();
		endfunction

		function void push_byte(input logic [7:0] b);
			pud_pkg::res_t r;
			r.data = b;
			r.last = 1'b0;
			decoded_q.push_back(r);
		endfunction

		// Works out the bytes one accepted request causes.
		function void note_request(input logic [7:0] b, input logic eol);
			logic [4:0] dv;
			logic [4:0] hv;
			int         first;
			first = decoded_q.size();
			dv = hex_digit_value(b);
			hv = hex_digit_value(held);
			if (pend == pud_pkg::PEND_DIGIT && dv < 16) begin
				// escape complete
				push_byte({hv[3:0], dv[3:0]});
				pend = pud_pkg::PEND_NONE;
			end else if (pend == pud_pkg::PEND_PCT && dv < 16) begin
				held = b;
				pend = pud_pkg::PEND_DIGIT;
			end else begin
				// broken escape: flush what is held, then look at this byte afresh
				if (pend != pud_pkg::PEND_NONE) push_byte(pud_pkg::PCT_CHAR);
				if (pend == pud_pkg::PEND_DIGIT) push_byte(held);
				if (b == pud_pkg::PCT_CHAR) begin
					pend = pud_pkg::PEND_PCT;
				end else begin
					push_byte(b);
					pend = pud_pkg::PEND_NONE;
				end
			end
			if (eol) begin
				if (pend != pud_pkg::PEND_NONE) push_byte(pud_pkg::PCT_CHAR);
				if (pend == pud_pkg::PEND_DIGIT) push_byte(held);
				pend = pud_pkg::PEND_NONE;
				held = 8'h00;
				if (decoded_q.size() > first) decoded_q[decoded_q.size() - 1].last = 1'b1;
			end
		endfunction

		function void check_byte(input logic [7:0] b, input logic l);
			pud_pkg::res_t r;
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected output byte %02h last %0b", $time, b, l);
				errors++;
				return;
			end
			r = decoded_q.pop_front();
			if (b !== r.data) begin
				$display("%0t: out_byte mismatch: expected %02h, actual %02h", $time, r.data, b);
				errors++;
			end
			if (l !== r.last) begin
				$display("%0t: out_last mismatch: expected %0b, actual %0b", $time, r.last, l);
				errors++;
			end
		endfunction
	endclass

	unescape_scoreboard sb = new();

	// Idle burst length: mostly short, a few long.
	function automatic int burst_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	function automatic int send_gap();
		if (quiet || $urandom_range(0, 99) < 55) return 0;
		return burst_len();
	endfunction

	// Random hex digit, either case for letters.
	function automatic logic [7:0] random_hex();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) return 8'("0" + v);
		return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
	endfunction

	// Byte that breaks an escape; sometimes '%' so a new escape starts right there.
	function automatic logic [7:0] random_non_hex();
		logic [7:0] b;
		if ($urandom_range(0, 4) == 0) return pud_pkg::PCT_CHAR;
		do b = 8'($urandom_range(0, 255)); while (hex_digit_value(b) < 16);
		return b;
	endfunction

	// Sample both handshakes at the edge; everything here reads pre-edge values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_request(data_byte, line_end);
			if (out_valid && !out_stall) sb.check_byte(out_byte, out_last);
		end
	end

	// Result side backpressure: runs of stall of random length, none while quiet.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (quiet || $urandom_range(0, 99) < 75) begin
			out_stall <= 1'b0;
		end else begin
			stall_left = burst_len() - 1;
			out_stall <= 1'b1;
		end
	end

	// One request: optional idle gap, then hold the payload until accepted.
	// Returns right after the accepting edge, with no drive yet in that step.
	task automatic send_request(input logic [7:0] b, input logic e);
		int gap;
		gap = send_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		line_end <= e;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	// Hold off the sender until every predicted byte has come out.
	// Checked at the falling edge so the scoreboard is settled.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.outstanding() > 0);
		@(posedge clk);
	endtask

	// A line built from tokens: good escapes, plain bytes, broken escapes, lone '%', NUL.
	// One line in ten is pure noise with random line_end marks instead.
	task automatic send_line();
		logic [7:0] bytes_q[$];
		int         ntok;
		int         r;
		if ($urandom_range(0, 9) == 0) begin
			ntok = $urandom_range(1, 10);
			repeat (ntok) send_request(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		end else begin
			ntok = $urandom_range(1, 8);
			repeat (ntok) begin
				r = $urandom_range(0, 99);
				if (r < 35) begin
					bytes_q.push_back(pud_pkg::PCT_CHAR);
					bytes_q.push_back(random_hex());
					bytes_q.push_back(random_hex());
				end else if (r < 60) begin
					bytes_q.push_back(8'($urandom_range(0, 255)));
				end else if (r < 72) begin
					bytes_q.push_back(pud_pkg::PCT_CHAR);
					bytes_q.push_back(random_hex());
					bytes_q.push_back(random_non_hex());
				end else if (r < 82) begin
					bytes_q.push_back(pud_pkg::PCT_CHAR);
					bytes_q.push_back(random_non_hex());
				end else if (r < 90) begin
					bytes_q.push_back(pud_pkg::PCT_CHAR);
				end else begin
					bytes_q.push_back(8'h00);
				end
			end
			foreach (bytes_q[i]) send_request(bytes_q[i], i == bytes_q.size() - 1);
		end
		lines_sent++;
	endtask

	initial begin
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		line_end <= 1'b0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: upper/lower case escapes, zero and all-ones results,
		// NUL after '%', broken escapes with and without a digit, a broken
		// escape ending on '%', and line ends with each kind of pending state.
		send_request("%", 1'b0); send_request("4", 1'b0); send_request("1", 1'b0);
		send_request("%", 1'b0); send_request("f", 1'b0); send_request("F", 1'b0);
		send_request("%", 1'b0); send_request("0", 1'b0); send_request("0", 1'b0);
		send_request("%", 1'b0); send_request(8'h00, 1'b0);
		send_request("%", 1'b0); send_request("a", 1'b0); send_request("g", 1'b0);
		send_request("%", 1'b0); send_request("B", 1'b0); send_request("%", 1'b0);
		send_request("7", 1'b0); send_request("e", 1'b0);
		send_request(8'hFF, 1'b0);
		send_request("%", 1'b0); send_request("C", 1'b1);
		send_request("%", 1'b1);
		send_request(8'h00, 1'b1);
		send_request("%", 1'b0); send_request("2", 1'b0); send_request("5", 1'b1);

		// Sender waits for the queue to empty before the random part.
		wait_for_drain();

		requests_sent = 0;
		while (requests_sent < RANDOM_REQUESTS) begin
			// A mid-run full drain, then a stretch of back-to-back traffic.
			if (lines_sent == 15) wait_for_drain();
			quiet = (lines_sent >= 20 && lines_sent < 32);
			send_line();
		end
		quiet = 1'b0;

		in_valid <= 1'b0;
		do @(negedge clk); while (sb.outstanding() > 0);
		// Catch stray bytes after the last expected one.
		repeat (END_SETTLE) @(posedge clk);

		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("** percent_unescape_decoder_top: PASSED **");
		end else begin
			$display("** percent_unescape_decoder_top: FAILED **");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(RUN_LIMIT);
		$display("%0t: timeout, %0d bytes still expected", $time, sb.outstanding());
		$display("** percent_unescape_decoder_top: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
hdl/pud_pkg.sv
hdl/percent_unescape_decoder_top.sv
test/percent_unescape_decoder_top_tb.sv
